### rtl/pal_pkg.sv
`timescale 1ns / 1ps
package pal_pkg;

  localparam int KIND_W = 2;
  localparam int POS_W  = 8;
  localparam int WORD_W = 32;
  localparam int STAT_W = 2;

  localparam logic [KIND_W-1:0] KIND_INSERT  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DELETE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_GET     = 2'd2;
  localparam logic [KIND_W-1:0] KIND_REPLACE = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL   = 2'd1;
  localparam logic [STAT_W-1:0] ST_BADPOS = 2'd2;
  localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd3;

  localparam logic [1:0] CELL_HOLD  = 2'd0;
  localparam logic [1:0] CELL_INS   = 2'd1;
  localparam logic [1:0] CELL_DEL   = 2'd2;
  localparam logic [1:0] CELL_WRITE = 2'd3;

  typedef struct packed {
    logic [1:0]       op;
    logic [POS_W-1:0] idx;
  } pal_cmd_t;

endpackage

### rtl/pal_cell.sv
`timescale 1ns / 1ps
module pal_cell import pal_pkg::*; #(
  parameter int SW    = 32,
  parameter int INDEX = 0
) (
  input  logic          clk,
  input  pal_cmd_t      cmd,
  input  logic [SW-1:0] word,
  input  logic [SW-1:0] left,
  input  logic [SW-1:0] right,
  output logic [SW-1:0] q
);

  localparam logic [POS_W-1:0] MY_IDX = POS_W'(INDEX);

  logic [SW-1:0] q_next;

  always_comb begin
    q_next = q;
    case (cmd.op)
      CELL_INS: begin
        if (MY_IDX == cmd.idx) begin
          q_next = word;
        end else if (MY_IDX > cmd.idx) begin
          q_next = left;
        end
      end
      CELL_DEL: begin
        if (MY_IDX >= cmd.idx) begin
          q_next = right;
        end
      end
      CELL_WRITE: begin
        if (MY_IDX == cmd.idx) begin
          q_next = word;
        end
      end
      default: q_next = q;
    endcase
  end

  always_ff @(posedge clk) begin
    q <= q_next;
  end

endmodule

### rtl/positional_array_list_core.sv
`timescale 1ns / 1ps
// Bounded list of DEPTH words addressed by 1-based position, built as a row
// of cells that each hold one entry and pass it to a neighbor on insert or
// delete. One request is taken per clock while the result register is free or
// being taken; each result is registered in the cycle after its request, and
// the whole row shifts in that same cycle. Entry words are stored at
// DATA_WIDTH bits (at most 32) and read back zero-extended.
module positional_array_list_core import pal_pkg::*; #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32,
  parameter int CW         = $clog2(DEPTH + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  logic [KIND_W-1:0] kind,
  input  logic [POS_W-1:0]  position,
  input  logic [WORD_W-1:0] element_data,
  output logic              res_valid,
  input  logic              res_ready,
  output logic [STAT_W-1:0] status,
  output logic [WORD_W-1:0] read_data,
  output logic [CW-1:0]     entry_count,
  output logic              is_empty,
  output logic              is_full
);

  localparam int SW = (DATA_WIDTH < WORD_W) ? DATA_WIDTH : WORD_W;
  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  logic [CW-1:0]     count;
  logic [CW-1:0]     count_next;
  logic [STAT_W-1:0] st;
  logic              accept;
  logic [POS_W:0]    pos_x;
  logic [POS_W:0]    cnt_x;
  logic [POS_W-1:0]  pidx;
  logic [SW-1:0]     word;
  logic [SW-1:0]     cell_q [DEPTH];
  pal_cmd_t          cmd;
  logic [WORD_W-1:0] rd;

  assign req_ready = !res_valid || res_ready;
  assign accept    = req_valid && req_ready;
  assign pos_x     = {1'b0, position};
  assign cnt_x     = (POS_W + 1)'(count);
  assign pidx      = position - POS_W'(1);
  assign word      = element_data[SW-1:0];

  always_comb begin
    st = ST_OK;
    if (kind == KIND_INSERT) begin
      if (count == DEPTH_C) begin
        st = ST_FULL;
      end else if (position == '0 || pos_x > cnt_x + (POS_W + 1)'(1)) begin
        st = ST_BADPOS;
      end
    end else begin
      if (count == '0) begin
        st = ST_EMPTY;
      end else if (position == '0 || pos_x > cnt_x) begin
        st = ST_BADPOS;
      end
    end
  end

  always_comb begin
    cmd.op     = CELL_HOLD;
    cmd.idx    = pidx;
    count_next = count;
    rd         = '0;
    if (accept && st == ST_OK) begin
      case (kind)
        KIND_INSERT: begin
          cmd.op     = CELL_INS;
          count_next = count + CW'(1);
        end
        KIND_DELETE: begin
          cmd.op     = CELL_DEL;
          count_next = count - CW'(1);
        end
        KIND_GET: rd = WORD_W'(cell_q[pidx[IW-1:0]]);
        KIND_REPLACE: cmd.op = CELL_WRITE;
        default: cmd.op = CELL_HOLD;
      endcase
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [SW-1:0] left;
    logic [SW-1:0] right;
    if (i == 0) begin : g_first
      assign left = word;
    end else begin : g_mid_l
      assign left = cell_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right = cell_q[i];
    end else begin : g_mid_r
      assign right = cell_q[i+1];
    end
    pal_cell #(.SW(SW), .INDEX(i)) u_cell (
      .clk   (clk),
      .cmd   (cmd),
      .word  (word),
      .left  (left),
      .right (right),
      .q     (cell_q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status      <= st;
      read_data   <= rd;
      entry_count <= count_next;
      is_empty    <= (count_next == '0);
      is_full     <= (count_next == DEPTH_C);
    end
  end

endmodule

### rtl/pal_checker.sv
`timescale 1ns / 1ps
module pal_checker import pal_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int CW    = 5
) (
  input logic              clk,
  input logic              rst,
  input logic              res_valid,
  input logic              res_ready,
  input logic [STAT_W-1:0] status,
  input logic [WORD_W-1:0] read_data,
  input logic [CW-1:0]     entry_count,
  input logic              is_empty,
  input logic              is_full
);

  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (is_empty == (entry_count == '0)))
    else $error("is_empty disagrees with entry_count");

  a_full_flag: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (is_full == (entry_count == DEPTH_C)))
    else $error("is_full disagrees with entry_count");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (entry_count <= DEPTH_C))
    else $error("entry_count above depth");

  a_read_ok: assert property (@(posedge clk) disable iff (rst)
    (res_valid && read_data != '0) |-> (status == ST_OK))
    else $error("read data on failed request");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> (res_valid && $stable(read_data) && $stable(status)
                                   && $stable(entry_count)))
    else $error("stalled result changed");

endmodule

bind positional_array_list_core pal_checker #(.DEPTH(DEPTH), .CW(CW)) u_pal_checker (
  .clk         (clk),
  .rst         (rst),
  .res_valid   (res_valid),
  .res_ready   (res_ready),
  .status      (status),
  .read_data   (read_data),
  .entry_count (entry_count),
  .is_empty    (is_empty),
  .is_full     (is_full)
);
